// File: src/layered_value_noise_2d_core_assert.svh
// Assertion macros for the layered value noise core.
`ifndef LAYERED_VALUE_NOISE_2D_CORE_ASSERT_SVH
`define LAYERED_VALUE_NOISE_2D_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LVN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lvn check failed");

// Next-cycle implication, checked outside reset.
`define LVN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lvn check failed");

`endif

// File: src/lvn_pkg.sv
package lvn_pkg;

    typedef logic [63:0] t_u64;

    localparam t_u64 GOLD = 64'h9e3779b97f4a7c15;
    localparam t_u64 MUL1 = 64'hbf58476d1ce4e5b9;
    localparam t_u64 MUL2 = 64'h94d049bb133111eb;

    localparam int NUM_OCT = 3;

    // Octave frequencies in Q0.32, salts, and weights in Q0.16.
    localparam logic [31:0] OCT_FREQ   [NUM_OCT] = '{32'd64424509, 32'd236223201, 32'd687194767};
    localparam t_u64        OCT_SALT   [NUM_OCT] = '{64'd11, 64'd23, 64'd37};
    localparam logic [15:0] OCT_WEIGHT [NUM_OCT] = '{16'd40632, 16'd18350, 16'd6553};

    localparam logic [3:0] ADDR_NOISE_SEED = 4'h0;

endpackage

// File: src/lvn_mix.sv
module lvn_mix
    import lvn_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_u64 i_a,
    input  t_u64 i_b,
    output t_u64 o_h
);

    t_u64        n_t0, n_t, n_u0, n_u, n_w0, n_w;
    t_u64        r_t, r_u, r_h;
    t_u64        r_p0, r_q0;
    logic [31:0] r_p1, r_p2, r_q1, r_q2;

    always_comb begin
        n_t0 = i_a ^ (i_b + GOLD + (i_a << 6) + (i_a >> 2));
        n_t  = n_t0 ^ (n_t0 >> 30);
        // Low 64 bits of a 64x64 product from three 32x32 partial products.
        n_u0 = r_p0 + {r_p1 + r_p2, 32'd0};
        n_u  = n_u0 ^ (n_u0 >> 27);
        n_w0 = r_q0 + {r_q1 + r_q2, 32'd0};
        n_w  = n_w0 ^ (n_w0 >> 31);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t  <= n_t;
            r_p0 <= 64'(r_t[31:0]) * 64'(MUL1[31:0]);
            r_p1 <= r_t[31:0] * MUL1[63:32];
            r_p2 <= r_t[63:32] * MUL1[31:0];
            r_u  <= n_u;
            r_q0 <= 64'(r_u[31:0]) * 64'(MUL2[31:0]);
            r_q1 <= r_u[31:0] * MUL2[63:32];
            r_q2 <= r_u[63:32] * MUL2[31:0];
            r_h  <= n_w;
        end
    end

    assign o_h = r_h;

endmodule

// File: src/lvn_octave.sv
module lvn_octave
    import lvn_pkg::*;
#(
    parameter int OCT             = 0,
    parameter int COORD_FRAC_BITS = 16,
    parameter int OUT_BITS        = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  t_u64                i_seed,
    input  logic [47:0]         i_x,
    input  logic [47:0]         i_y,
    output logic [OUT_BITS-1:0] o_val
);

    localparam int          CFB   = COORD_FRAC_BITS;
    localparam int          PW    = OUT_BITS + 18;
    localparam logic [31:0] FREQ  = OCT_FREQ[OCT];
    localparam t_u64        SALT  = OCT_SALT[OCT];
    localparam int          FDLY  = 13;
    localparam int          CYDLY = 5;

    // Scale stage.
    logic        [55:0] r_pxl, r_pyl;
    logic signed [56:0] r_pxh, r_pyh;
    logic signed [56:0] n_pxh, n_pyh;
    logic signed [80:0] n_sx80, n_sy80;
    logic        [47:0] n_sx, n_sy;
    t_u64               n_cx, n_cy;
    logic        [15:0] n_tx, n_ty;
    t_u64               r_cx, r_cx1, r_cy, r_cy1;
    logic        [15:0] r_tx, r_ty;

    // Fade stages.
    logic [15:0] r_t2x, r_t2y, r_txd, r_tyd;
    logic [16:0] r_fx, r_fy;
    logic [16:0] r_fxd [FDLY];
    logic [16:0] r_fyd [FDLY];
    t_u64        r_cyd  [CYDLY];
    t_u64        r_cy1d [CYDLY];

    // Hash chain.
    t_u64 h1_0, h1_1, h2_00, h2_10, h2_01, h2_11;
    t_u64 h3_00, h3_10, h3_01, h3_11;

    // Blend stages.
    logic [OUT_BITS-1:0]        c_a, c_b, c_c, c_d;
    logic signed [OUT_BITS:0]   n_dab, n_dcd, n_dfe;
    logic signed [PW-1:0]       r_pab, r_pcd, r_pfe;
    logic [OUT_BITS-1:0]        r_a, r_c, r_e, r_f, r_e2, r_oct;
    logic [16:0]                r_fy1, r_fy2;

    always_comb begin
        n_pxh  = 57'(signed'(i_x[47:24])) * 57'(signed'({1'b0, FREQ}));
        n_pyh  = 57'(signed'(i_y[47:24])) * 57'(signed'({1'b0, FREQ}));
        // The exact product, floored by taking the bits above the Q0.32 point.
        n_sx80 = (81'(r_pxh) <<< 24) + signed'({25'd0, r_pxl});
        n_sy80 = (81'(r_pyh) <<< 24) + signed'({25'd0, r_pyl});
        n_sx   = n_sx80[79:32];
        n_sy   = n_sy80[79:32];
        n_cx   = 64'(signed'(n_sx) >>> CFB);
        n_cy   = 64'(signed'(n_sy) >>> CFB);
        n_tx   = 16'({n_sx[CFB-1:0], 16'd0} >> CFB);
        n_ty   = 16'({n_sy[CFB-1:0], 16'd0} >> CFB);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxl <= 56'(i_x[23:0]) * 56'(FREQ);
            r_pyl <= 56'(i_y[23:0]) * 56'(FREQ);
            r_pxh <= n_pxh;
            r_pyh <= n_pyh;
            r_cx  <= n_cx;
            r_cx1 <= n_cx + 64'd1;
            r_cy  <= n_cy;
            r_cy1 <= n_cy + 64'd1;
            r_tx  <= n_tx;
            r_ty  <= n_ty;
            r_t2x <= 16'((32'(r_tx) * 32'(r_tx)) >> 16);
            r_t2y <= 16'((32'(r_ty) * 32'(r_ty)) >> 16);
            r_txd <= r_tx;
            r_tyd <= r_ty;
            r_fx  <= 17'((34'(r_t2x) * 34'(18'd196608 - {1'b0, r_txd, 1'b0})) >> 16);
            r_fy  <= 17'((34'(r_t2y) * 34'(18'd196608 - {1'b0, r_tyd, 1'b0})) >> 16);
            r_fxd[0]  <= r_fx;
            r_fyd[0]  <= r_fy;
            for (int i = 1; i < FDLY; i++) begin
                r_fxd[i] <= r_fxd[i-1];
                r_fyd[i] <= r_fyd[i-1];
            end
            r_cyd[0]  <= r_cy;
            r_cy1d[0] <= r_cy1;
            for (int i = 1; i < CYDLY; i++) begin
                r_cyd[i]  <= r_cyd[i-1];
                r_cy1d[i] <= r_cy1d[i-1];
            end
        end
    end

    // Corners that share a cell x share the first hash round.
    lvn_mix u_m1_0 (.i_clk, .i_en, .i_a(i_seed), .i_b(r_cx),  .o_h(h1_0));
    lvn_mix u_m1_1 (.i_clk, .i_en, .i_a(i_seed), .i_b(r_cx1), .o_h(h1_1));

    lvn_mix u_m2_00 (.i_clk, .i_en, .i_a(h1_0), .i_b(r_cyd[CYDLY-1]),  .o_h(h2_00));
    lvn_mix u_m2_10 (.i_clk, .i_en, .i_a(h1_1), .i_b(r_cyd[CYDLY-1]),  .o_h(h2_10));
    lvn_mix u_m2_01 (.i_clk, .i_en, .i_a(h1_0), .i_b(r_cy1d[CYDLY-1]), .o_h(h2_01));
    lvn_mix u_m2_11 (.i_clk, .i_en, .i_a(h1_1), .i_b(r_cy1d[CYDLY-1]), .o_h(h2_11));

    lvn_mix u_m3_00 (.i_clk, .i_en, .i_a(h2_00), .i_b(SALT), .o_h(h3_00));
    lvn_mix u_m3_10 (.i_clk, .i_en, .i_a(h2_10), .i_b(SALT), .o_h(h3_10));
    lvn_mix u_m3_01 (.i_clk, .i_en, .i_a(h2_01), .i_b(SALT), .o_h(h3_01));
    lvn_mix u_m3_11 (.i_clk, .i_en, .i_a(h2_11), .i_b(SALT), .o_h(h3_11));

    always_comb begin
        c_a   = h3_00[63 -: OUT_BITS];
        c_b   = h3_10[63 -: OUT_BITS];
        c_c   = h3_01[63 -: OUT_BITS];
        c_d   = h3_11[63 -: OUT_BITS];
        n_dab = signed'({1'b0, c_b}) - signed'({1'b0, c_a});
        n_dcd = signed'({1'b0, c_d}) - signed'({1'b0, c_c});
        n_dfe = signed'({1'b0, r_f}) - signed'({1'b0, r_e});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pab <= PW'(n_dab) * PW'(signed'({1'b0, r_fxd[FDLY-1]}));
            r_pcd <= PW'(n_dcd) * PW'(signed'({1'b0, r_fxd[FDLY-1]}));
            r_a   <= c_a;
            r_c   <= c_c;
            r_fy1 <= r_fyd[FDLY-1];
            r_e   <= r_a + OUT_BITS'(r_pab >>> 16);
            r_f   <= r_c + OUT_BITS'(r_pcd >>> 16);
            r_fy2 <= r_fy1;
            r_pfe <= PW'(n_dfe) * PW'(signed'({1'b0, r_fy2}));
            r_e2  <= r_e;
            r_oct <= r_e2 + OUT_BITS'(r_pfe >>> 16);
        end
    end

    assign o_val = r_oct;

endmodule

// File: src/layered_value_noise_2d_core.sv
// Channel   Direction  Word contents (low bits first)
// s_axis    in         x_coord[47:0], y_coord[95:48]
// m_axis    out        noise_value[OUT_BITS-1:0], zero filled to whole bytes
// apb       in/out     noise_seed at byte address 0, 64-bit data
//
// One word is taken every cycle while nothing stalls; each word shows on m_axis after passing
// the 24 register stages of the input, scale, hash, blend and weighting pipeline.
// Reset is synchronous, active low; it clears the valid bits and the seed.
// While a finished word waits on m_axis the whole pipeline holds, so s_axis_tready falls.
module layered_value_noise_2d_core
    import lvn_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16,
    parameter int OUT_BITS        = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // x_coord, y_coord
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [((OUT_BITS+7)/8)*8-1:0] m_axis_tdata,   // noise_value
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int LAT   = 24;
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int WW    = OUT_BITS + 16;
    localparam int SW    = OUT_BITS + 18;

    logic                r_vld [LAT];
    logic                en;
    t_u64                r_seed;
    logic [47:0]         r_x, r_y;
    logic [OUT_BITS-1:0] oct_val [NUM_OCT];
    logic [WW-1:0]       r_wp [NUM_OCT];
    logic [SW-1:0]       n_sum;
    logic [OUT_BITS-1:0] r_out;

    assign en            = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[LAT-1];
    assign m_axis_tdata  = OUT_W'(r_out);
    assign pready        = 1'b1;
    assign prdata        = (paddr == ADDR_NOISE_SEED) ? r_seed : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && (paddr == ADDR_NOISE_SEED)) begin
            r_seed <= pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    for (genvar k = 0; k < NUM_OCT; k++) begin : g_oct
        lvn_octave #(
            .OCT             (k),
            .COORD_FRAC_BITS (COORD_FRAC_BITS),
            .OUT_BITS        (OUT_BITS)
        ) u_oct (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_seed (r_seed),
            .i_x    (r_x),
            .i_y    (r_y),
            .o_val  (oct_val[k])
        );
    end

    // The weights sum to just under one, so the sum never spills past OUT_BITS.
    assign n_sum = SW'(r_wp[0]) + SW'(r_wp[1]) + SW'(r_wp[2]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x <= s_axis_tdata[47:0];
            r_y <= s_axis_tdata[95:48];
            for (int k = 0; k < NUM_OCT; k++) begin
                r_wp[k] <= WW'(oct_val[k]) * WW'(OCT_WEIGHT[k]);
            end
            r_out <= n_sum[16 +: OUT_BITS];
        end
    end

    `include "layered_value_noise_2d_core_assert.svh"

    `LVN_ASSERT_NEXT(a_hold_on_stall, !en, m_axis_tvalid && $stable(r_vld[LAT-2]))
    `LVN_ASSERT_NEXT(a_advance, en && r_vld[LAT-2], m_axis_tvalid)
    `LVN_ASSERT_NOW(a_sum_range, r_vld[LAT-2], n_sum[SW-1:16+OUT_BITS] == '0)

endmodule
